>>> design/sha256_stream_hasher_defines.svh
// Assertion helpers for the hasher; clock and reset are taken from the using module.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication.
`define SHS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/shs_pkg.sv
package shs_pkg;

   typedef struct packed {
      logic [7:0] message_byte;
      logic       byte_present;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // write request into the schedule memory from the intake side
   typedef struct packed {
      logic        en;
      logic [3:0]  addr;
      logic [31:0] data;
   } mem_wr_type;

   // one schedule word handed to the round logic
   typedef struct packed {
      logic        valid;
      logic [5:0]  round;
      logic [31:0] w;
   } w_beat_type;

   localparam logic [31:0] IV_TABLE [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic [31:0] K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

>>> design/shs_sched.sv
module shs_sched (
   input  logic               clock,
   input  logic               reset,
   input  shs_pkg::mem_wr_type host_wr,
   input  logic               start,
   output shs_pkg::w_beat_type beat,
   output logic               busy
);
   import shs_pkg::*;

   localparam logic [1:0] PH_READ_A = 2'd0;
   localparam logic [1:0] PH_READ_B = 2'd1;
   localparam logic [1:0] PH_SUM    = 2'd2;
   localparam logic [1:0] PH_EMIT   = 2'd3;

   logic [31:0] mem [16];
   logic [31:0] rd0_ff, rd1_ff;
   logic        busy_ff, busy_in;
   logic [5:0]  round_ff, round_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] partial_ff, partial_in;
   logic [31:0] w_ff, w_in;
   logic [3:0]  addr0, addr1;
   logic        high;
   logic        wr_en;
   logic [3:0]  wr_addr;
   logic [31:0] wr_data;

   // rounds 16..63 expand the schedule in place
   assign high = |round_ff[5:4];

   always_comb begin
      addr0 = round_ff[3:0];
      addr1 = round_ff[3:0];
      unique case (phase_ff) inside
         PH_READ_A: begin
            addr0 = high ? round_ff[3:0] - 4'd2 : round_ff[3:0];
            addr1 = round_ff[3:0] + 4'd1;           // r - 15
         end
         PH_READ_B: begin
            addr0 = round_ff[3:0] - 4'd7;
            addr1 = round_ff[3:0];                  // r - 16
         end
         PH_SUM, PH_EMIT: begin
            addr0 = round_ff[3:0];
            addr1 = round_ff[3:0];
         end
         default: begin
            addr0 = round_ff[3:0];
            addr1 = round_ff[3:0];
         end
      endcase
   end

   always_comb begin
      busy_in    = busy_ff;
      round_in   = round_ff;
      phase_in   = phase_ff;
      partial_in = partial_ff;
      w_in       = w_ff;
      if (start) begin
         busy_in  = 1'b1;
         round_in = '0;
         phase_in = PH_READ_A;
      end else if (busy_ff) begin
         phase_in = phase_ff + 2'd1;
         unique case (phase_ff)
            PH_READ_A: ;
            PH_READ_B: begin
               if (high) partial_in = ssig1(rd0_ff) + ssig0(rd1_ff);
               else      w_in       = rd0_ff;
            end
            PH_SUM: begin
               if (high) w_in = partial_ff + rd0_ff + rd1_ff;
            end
            PH_EMIT: begin
               round_in = round_ff + 6'd1;
               if (round_ff == 6'd63) busy_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (busy_ff) begin
         wr_en   = (phase_ff == PH_EMIT) && high;
         wr_addr = round_ff[3:0];
         wr_data = w_ff;
      end else begin
         wr_en   = host_wr.en;
         wr_addr = host_wr.addr;
         wr_data = host_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd0_ff <= mem[addr0];
      rd1_ff <= mem[addr1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= '0;
         phase_ff <= PH_READ_A;
      end else begin
         busy_ff  <= busy_in;
         round_ff <= round_in;
         phase_ff <= phase_in;
      end
      partial_ff <= partial_in;
      w_ff       <= w_in;
   end

   assign beat.valid = busy_ff && (phase_ff == PH_EMIT);
   assign beat.round = round_ff;
   assign beat.w     = w_ff;
   assign busy       = busy_ff;

endmodule

>>> design/shs_core.sv
module shs_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                restart,
   input  shs_pkg::w_beat_type beat,
   input  logic [2:0]          rd_idx,
   output logic [31:0]         rd_word,
   output logic                done
);
   import shs_pkg::*;

   logic [31:0] chain_ff [8];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   logic        fin_ff, fin_in;
   logic [31:0] t1, t2;

   // one round per beat
   assign t1 = h_ff + bsig1(e_ff) + (g_ff ^ (e_ff & (f_ff ^ g_ff)))
             + K_TABLE[beat.round] + beat.w;
   assign t2 = bsig0(a_ff) + ((a_ff & b_ff) | (c_ff & (a_ff | b_ff)));

   assign fin_in = beat.valid && (beat.round == 6'd63);

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
         f_ff <= chain_ff[5];
         g_ff <= chain_ff[6];
         h_ff <= chain_ff[7];
      end else if (beat.valid) begin
         a_ff <= t1 + t2;
         b_ff <= a_ff;
         c_ff <= b_ff;
         d_ff <= c_ff;
         e_ff <= d_ff + t1;
         f_ff <= e_ff;
         g_ff <= f_ff;
         h_ff <= g_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int j = 0; j < 8; j++) chain_ff[j] <= IV_TABLE[j];
      end else if (fin_ff) begin
         chain_ff[0] <= chain_ff[0] + a_ff;
         chain_ff[1] <= chain_ff[1] + b_ff;
         chain_ff[2] <= chain_ff[2] + c_ff;
         chain_ff[3] <= chain_ff[3] + d_ff;
         chain_ff[4] <= chain_ff[4] + e_ff;
         chain_ff[5] <= chain_ff[5] + f_ff;
         chain_ff[6] <= chain_ff[6] + g_ff;
         chain_ff[7] <= chain_ff[7] + h_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) fin_ff <= 1'b0;
      else       fin_ff <= fin_in;
   end

   assign done    = fin_ff;
   assign rd_word = chain_ff[rd_idx];

endmodule

>>> design/sha256_stream_hasher.sv
// SHA-256 over a byte stream.
// Input channel req_*: one transaction carries at most one message byte
// (byte_present) and may close the message (message_end, after its own byte).
// Output channel rsp_*: eight transactions per message, digest words 0..7,
// most significant first, last_word set on word 7.
// Bytes are packed four to a word into a 16-word schedule memory; the
// compression reads that memory back (two registered read ports) and
// expands the schedule in place. Byte transactions are taken back to back
// while idle; the byte that fills a block holds off the next transaction
// while that block is compressed. A closing transaction is followed by
// padding writes for one or two blocks, a compression per block, the load
// of the first digest word, then the eight words, one per cycle while
// rsp_ready. req_ready is low from a block fill until its compression is
// done, and from a close until the last digest word is taken; a stalled
// receiver just holds the current word in the output register. Reset
// (synchronous) loads the initial hash values and empties the block; the
// schedule memory needs no clearing.
`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  shs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output shs_pkg::rsp_type rsp_data
);
   import shs_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;  // taking bytes
   localparam logic [2:0] ST_COMP = 3'd1;  // compression running
   localparam logic [2:0] ST_PAD  = 3'd2;  // write the word holding 0x80
   localparam logic [2:0] ST_FILL = 3'd3;  // zero / length words
   localparam logic [2:0] ST_OUT  = 3'd4;  // digest out

   logic [2:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;        // bytes pending in current block
   logic [31:0] acc_ff, acc_in;          // partial word, newest byte lowest
   logic [63:0] bits_ff, bits_in;        // message length in bits, wraps
   logic        end_ff, end_in;          // message is closing
   logic        pad_ff, pad_in;          // 0x80 already placed
   logic        final_ff, final_in;      // block in flight carries the length
   logic [3:0]  widx_ff, widx_in;
   logic [3:0]  cnt_ff, cnt_in;          // digest words loaded
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   mem_wr_type  host_wr;
   w_beat_type  beat;
   logic        sched_busy;
   logic        start;
   logic        restart;
   logic        core_done;
   logic [31:0] chain_word;
   logic [31:0] word_done;
   logic [31:0] pad_word;
   logic        rsp_load;

   shs_sched u_sched (
      .clock   (clock),
      .reset   (reset),
      .host_wr (host_wr),
      .start   (start),
      .beat    (beat),
      .busy    (sched_busy)
   );

   shs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .restart (restart),
      .beat    (beat),
      .rd_idx  (cnt_ff[2:0]),
      .rd_word (chain_word),
      .done    (core_done)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign word_done = {acc_ff[23:0], req_data.message_byte};
   assign rsp_load  = !rsp_valid_ff || rsp_ready;

   // 0x80 goes right after the pending bytes of the partial word
   always_comb begin
      case (fill_ff[1:0])
         2'd0:    pad_word = 32'h8000_0000;
         2'd1:    pad_word = {acc_ff[7:0], 8'h80, 16'h0000};
         2'd2:    pad_word = {acc_ff[15:0], 8'h80, 8'h00};
         default: pad_word = {acc_ff[23:0], 8'h80};
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      acc_in       = acc_ff;
      bits_in      = bits_ff;
      end_in       = end_ff;
      pad_in       = pad_ff;
      final_in     = final_ff;
      widx_in      = widx_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      host_wr      = '0;
      start        = 1'b0;
      restart      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.byte_present) begin
                  acc_in  = word_done;
                  fill_in = fill_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
                  if (fill_ff[1:0] == 2'd3) begin
                     host_wr.en   = 1'b1;
                     host_wr.addr = fill_ff[5:2];
                     host_wr.data = word_done;
                  end
               end
               if (req_data.byte_present && (fill_ff == 6'd63)) begin
                  start    = 1'b1;
                  end_in   = req_data.message_end;
                  state_in = ST_COMP;
               end else if (req_data.message_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_COMP: begin
            if (core_done) begin
               if (final_ff) begin
                  cnt_in   = '0;
                  state_in = ST_OUT;
               end else if (end_ff && !pad_ff) begin
                  state_in = ST_PAD;
               end else if (end_ff) begin
                  // second padding block: zeros then the length
                  widx_in  = '0;
                  final_in = 1'b1;
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PAD: begin
            host_wr.en   = 1'b1;
            host_wr.addr = fill_ff[5:2];
            host_wr.data = pad_word;
            pad_in       = 1'b1;
            end_in       = 1'b1;
            final_in     = (fill_ff < 6'd56);
            fill_in      = '0;
            if (fill_ff[5:2] == 4'd15) begin
               start    = 1'b1;
               state_in = ST_COMP;
            end else begin
               widx_in  = fill_ff[5:2] + 4'd1;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            host_wr.en   = 1'b1;
            host_wr.addr = widx_ff;
            if (final_ff && (widx_ff == 4'd14))      host_wr.data = bits_ff[63:32];
            else if (final_ff && (widx_ff == 4'd15)) host_wr.data = bits_ff[31:0];
            else                                     host_wr.data = '0;
            if (widx_ff == 4'd15) begin
               start    = 1'b1;
               state_in = ST_COMP;
            end else begin
               widx_in = widx_ff + 4'd1;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               if (!cnt_ff[3]) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.digest_word = chain_word;
                  rsp_data_in.word_index  = cnt_ff[2:0];
                  rsp_data_in.last_word   = (cnt_ff[2:0] == 3'd7);
                  cnt_in                  = cnt_ff + 4'd1;
               end else begin
                  // last word taken: back to the initial values
                  rsp_valid_in = 1'b0;
                  restart      = 1'b1;
                  bits_in      = '0;
                  end_in       = 1'b0;
                  pad_in       = 1'b0;
                  final_in     = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         bits_ff      <= '0;
         end_ff       <= 1'b0;
         pad_ff       <= 1'b0;
         final_ff     <= 1'b0;
         widx_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         end_ff       <= end_in;
         pad_ff       <= pad_in;
         final_ff     <= final_in;
         widx_ff      <= widx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SHS_ASSERT_SAME(a_no_intake_during_digest, rsp_valid, !req_ready, "input taken while digest pending")
   `SHS_ASSERT_SAME(a_done_only_in_comp, core_done, state_ff == ST_COMP, "compression done outside wait")
   `SHS_ASSERT_SAME(a_no_write_while_busy, host_wr.en, !sched_busy, "memory write during compression")
   `SHS_ASSERT_NEXT(a_last_drains, rsp_valid && rsp_ready && rsp_data.last_word, !rsp_valid, "output not drained after last word")

endmodule

>>> verif/sha256_stream_hasher_test.sv
`timescale 1ns / 100ps

module sha256_stream_hasher_test;
   import shs_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 220;
   // the last stretch of the run goes without any idling
   localparam int unsigned CALM_ITEMS   = 40;
   // long receiver hold-off, so the input backs up
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned TAIL_CYCLES  = 40;
   // worst quiet gap: two compressions plus the long hold plus a burst
   localparam int unsigned STALL_LIMIT  = 4000;

   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

   localparam logic [31:0] HASH_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // directed row: one request, and a typed-in digest where it is well known
   typedef struct {
      req_type      item;
      bit           typed;
      logic [255:0] digest;
   } plan_row_type;

   // empty message, "abc" closed on its last byte and on a separate
   // byteless close, no-op items with a junk byte, extreme byte values
   localparam int unsigned PLAN_ROWS = 15;
   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
      '{'{8'h61, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h62, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h63, 1'b1, 1'b1}, 1'b1, ABC_DIGEST},
      '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h61, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h62, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h63, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h5a, 1'b0, 1'b1}, 1'b1, ABC_DIGEST},
      '{'{8'h00, 1'b1, 1'b1}, 1'b0, '0},
      '{'{8'hff, 1'b1, 1'b1}, 1'b0, '0},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hff, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b1, 1'b1}, 1'b0, '0},
      '{'{8'hff, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // hasher state as the predictor tracks it
   logic [31:0] chain_h [8];
   logic [7:0]  block_bytes [64];
   int unsigned block_fill;
   logic [63:0] message_bits;

   rsp_type     digest_words_due [$];

   bit          calm_tail     = 1'b0;
   bit          hold_receiver = 1'b0;
   int unsigned fails         = 0;
   int unsigned words_checked = 0;
   int unsigned digests_seen  = 0;
   int unsigned items_sent    = 0;
   int unsigned noop_items    = 0;
   int unsigned idle_cycles   = 0;

   always #6 clock = ~clock;

   sha256_stream_hasher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic void restart_message();
      chain_h      = HASH_IV;
      block_fill   = 0;
      message_bits = '0;
   endfunction

   // one 64-round compression of block_bytes into chain_h
   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1;
      logic [31:0] t2;
      for (int j = 0; j < 16; j++)
         w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2], block_bytes[4*j+3]};
      for (int j = 16; j < 64; j++)
         w[j] = (rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10)) + w[j-7]
              + (rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3)) + w[j-16];
      v = chain_h;
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int j = 7; j > 0; j--)
            v[j] = v[j-1];
         v[4] = v[4] + t1;   // old d + t1
         v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++)
         chain_h[j] = chain_h[j] + v[j];
   endfunction

   // Takes one accepted transaction; returns 1 with the digest when it closes
   // a message. Message length wrap at 2^64 bits is out of reach in a run.
   function automatic bit sha_absorb(input req_type item, output logic [255:0] digest);
      digest = '0;
      if (item.byte_present) begin
         block_bytes[block_fill] = item.message_byte;
         block_fill++;
         message_bits += 64'd8;
         if (block_fill == 64) begin
            compress_block();
            block_fill = 0;
         end
      end
      if (!item.message_end)
         return 1'b0;
      block_bytes[block_fill] = 8'h80;
      block_fill++;
      // no room for the length: pad out and compress an extra block
      if (block_fill > 56) begin
         while (block_fill < 64) begin
            block_bytes[block_fill] = 8'h00;
            block_fill++;
         end
         compress_block();
         block_fill = 0;
      end
      while (block_fill < 56) begin
         block_bytes[block_fill] = 8'h00;
         block_fill++;
      end
      for (int j = 0; j < 8; j++)
         block_bytes[56+j] = message_bits[63-8*j -: 8];
      compress_block();
      for (int j = 0; j < 8; j++)
         digest[255-32*j -: 32] = chain_h[j];
      restart_message();
      return 1'b1;
   endfunction

   // Offers one transaction, at times after a random gap (never in the calm
   // tail), and queues the digest words it causes once it is accepted.
   task automatic offer(input req_type item, input bit typed, input logic [255:0] typed_digest);
      logic [255:0] digest;
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (sha_absorb(item, digest)) begin
         if (typed)
            digest = typed_digest;
         for (int j = 0; j < 8; j++)
            digest_words_due.push_back('{digest[255-32*j -: 32], 3'(j), j == 7});
      end
   endtask

   // sender goes quiet until every queued digest word has come back
   task automatic wait_digests_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (digest_words_due.size() != 0) @(posedge clock);
   endtask

   task automatic send_message(input int unsigned len);
      req_type item;
      bit      close_on_byte;
      close_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
      for (int unsigned n = 0; n < len; n++) begin
         // now and then a no-op transaction with a junk byte
         if ($urandom_range(0, 11) == 0) begin
            item = '{8'($urandom_range(0, 255)), 1'b0, 1'b0};
            offer(item, 1'b0, '0);
            noop_items++;
         end
         item = '{8'($urandom_range(0, 255)), 1'b1, close_on_byte && (n == len - 1)};
         offer(item, 1'b0, '0);
         items_sent++;
      end
      if (!close_on_byte) begin
         item = '{8'($urandom_range(0, 255)), 1'b0, 1'b1};
         offer(item, 1'b0, '0);
         items_sent++;
      end
   endtask

   // Receiver: random stall bursts, one long hold-off on request, none at the end.
   initial begin : receiver
      forever begin
         if (hold_receiver) begin
            hold_receiver = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Digest checker: every accepted word against the oldest one queued.
   always @(posedge clock) begin : digest_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_words_due.size() == 0) begin
            $display("%0t: unexpected digest word %h index %0d last %b", $time,
                     rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word);
            fails++;
         end else begin
            want = digest_words_due.pop_front();
            if (rsp_data.digest_word !== want.digest_word) begin
               $display("%0t: digest_word expected %h actual %h", $time,
                        want.digest_word, rsp_data.digest_word);
               fails++;
            end
            if (rsp_data.word_index !== want.word_index) begin
               $display("%0t: word_index expected %0d actual %0d", $time,
                        want.word_index, rsp_data.word_index);
               fails++;
            end
            if (rsp_data.last_word !== want.last_word) begin
               $display("%0t: last_word expected %b actual %b", $time,
                        want.last_word, rsp_data.last_word);
               fails++;
            end
            words_checked++;
            if (want.last_word)
               digests_seen++;
         end
      end
   end

   // Watchdog: too long without any transaction on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("sha256_stream_hasher_test NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned len;
      bit          paused_midway;
      paused_midway = 1'b0;
      restart_message();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         offer(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].digest);
         if (directed_plan[i].item.byte_present || directed_plan[i].item.message_end)
            items_sent++;
         else
            noop_items++;
      end
      wait_digests_drained();

      // Receiver holds off while the first random messages keep coming, so the
      // hasher fills up and drops req_ready.
      hold_receiver = 1'b1;
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         // lengths clustered where the padding needs one or two blocks
         case ($urandom_range(0, 9)) inside
            0, 1, 2: len = $urandom_range(0, 6);
            3, 4, 5: len = $urandom_range(52, 59);
            6:       len = $urandom_range(62, 66);
            7:       len = $urandom_range(118, 130);
            default: len = $urandom_range(0, 40);
         endcase
         // keep the run near its item budget
         if (len + 1 > RANDOM_ITEMS - items_sent)
            len = RANDOM_ITEMS - items_sent - 1;
         send_message(len);
         if (!paused_midway && items_sent >= RANDOM_ITEMS / 2) begin
            paused_midway = 1'b1;
            wait_digests_drained();
         end
         if (items_sent + CALM_ITEMS >= RANDOM_ITEMS)
            calm_tail = 1'b1;
      end

      wait_digests_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d message transactions and %0d no-op transactions", items_sent,
               noop_items);
      $display("checked %0d digest words in %0d digests, %0d mismatches", words_checked,
               digests_seen, fails);
      if (fails == 0)
         $display("sha256_stream_hasher_test OK");
      else
         $display("sha256_stream_hasher_test NOT OK");
      $finish;
   end

endmodule

>>> sha256_stream_hasher.f
+incdir+design
design/shs_pkg.sv
design/shs_sched.sv
design/shs_core.sv
design/sha256_stream_hasher.sv
verif/sha256_stream_hasher_test.sv
